// ----- rtl/lfpr_pkg.sv -----
// Shared constants, types and controller/datapath interface for the frame receiver.
package lfpr_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int MAX_PAYLOAD  = ((BUFFER_BYTES - 4) < 28) ? (BUFFER_BYTES - 4) : 28;
  localparam int RAM_AW       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;
  localparam int POS_W  = 6;
  localparam int ADDR_W = 3;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'h3C;
  localparam logic [BYTE_W-1:0] OP_SHORT     = 8'h01;
  localparam logic [BYTE_W-1:0] OP_BULK      = 8'h12;
  localparam logic [POS_W-1:0]  BASE_BYTES   = 6'd4;

  localparam logic [POS_W-1:0] POS_HEADER = 6'd0;
  localparam logic [POS_W-1:0] POS_OPCODE = 6'd1;
  localparam logic [POS_W-1:0] POS_LENGTH = 6'd2;
  localparam logic [POS_W-1:0] POS_DATA   = 6'd3;

  localparam logic [BYTE_W-1:0] MAX_LEN_BYTE = BYTE_W'(MAX_PAYLOAD);

  localparam logic REG_START_MARKER = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_FETCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic capture;
    logic close;
    logic abort;
    logic fetch;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic marker_hit;
    logic at_close;
    logic oversize;
    logic no_payload;
    logic run_last;
  } status_t;

endpackage

// ----- rtl/lfpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lfpr_ctrl.sv -----
// Frame receiver controller: receive, fetch and output sequencing.
module lfpr_ctrl
  import lfpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   in_acc;
  logic   out_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_stall   = !((state == ST_IDLE) || (state == ST_RECV));
    out_valid  = (state == ST_OUT);
    in_acc     = in_valid && !in_stall;
    out_acc    = out_valid && !out_stall;
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && status.marker_hit) begin
          cmd.start  = 1'b1;
          state_next = ST_RECV;
        end
      end
      ST_RECV: begin
        if (in_acc) begin
          priority if (status.at_close) begin
            cmd.close  = 1'b1;
            state_next = status.no_payload ? ST_OUT : ST_FETCH;
          end else if (status.oversize) begin
            cmd.abort  = 1'b1;
            state_next = ST_OUT;
          end else begin
            cmd.capture = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (status.run_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = ST_FETCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/lfpr_dp.sv -----
// Frame receiver datapath: byte capture, payload store and result fields.
module lfpr_dp
  import lfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [BYTE_W-1:0] start_marker,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic [BYTE_W-1:0] frame_header,
  output logic [BYTE_W-1:0] frame_opcode,
  output logic [LEN_W-1:0]  payload_length,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [LEN_W-1:0]  payload_position,
  output logic              payload_valid,
  output logic              checksum_ok,
  output logic              bulk_frame,
  output logic              oversize_error,
  output logic              last
);

  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  expected_bytes;
  logic [BYTE_W-1:0] hdr;
  logic [BYTE_W-1:0] op;
  logic [LEN_W-1:0]  len;
  logic [BYTE_W-1:0] ck;
  logic              err;
  logic [LEN_W-1:0]  run_idx;

  logic [POS_W-1:0]  data_off;
  logic              is_ck_pos;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic              short_op;
  logic [LEN_W-1:0]  rep_len;
  logic [BYTE_W-1:0] rep_ck;
  logic [BYTE_W-1:0] sum;
  logic              rep_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      expected_bytes <= BASE_BYTES;
      err            <= 1'b0;
      run_idx        <= '0;
    end else begin
      if (cmd.start) begin
        byte_position <= '0;
        err           <= 1'b0;
        run_idx       <= '0;
      end
      if (cmd.capture) begin
        byte_position <= byte_position + POS_W'(1);
        if (byte_position == POS_LENGTH) begin
          expected_bytes <= BASE_BYTES + POS_W'(rx_byte[LEN_W-1:0]);
        end
      end
      if (cmd.close || cmd.abort) begin
        byte_position  <= '0;
        expected_bytes <= BASE_BYTES;
      end
      if (cmd.abort) begin
        err <= 1'b1;
      end
      if (cmd.step) begin
        run_idx <= run_idx + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      unique case (byte_position)
        POS_HEADER: hdr <= rx_byte;
        POS_OPCODE: op  <= rx_byte;
        POS_LENGTH: len <= rx_byte[LEN_W-1:0];
        default: begin
          if (is_ck_pos) begin
            ck <= rx_byte;
          end
        end
      endcase
    end
  end

  assign data_off  = byte_position - POS_DATA;
  assign is_ck_pos = (byte_position == (expected_bytes - POS_W'(1)));
  assign ram_we    = cmd.capture && (byte_position >= POS_DATA) && !is_ck_pos;

  lfpr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(data_off[RAM_AW-1:0]),
    .wdata(rx_byte),
    .re   (cmd.fetch),
    .raddr(run_idx[RAM_AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    short_op = (op == OP_SHORT);
    rep_len  = short_op ? '0 : len;
    rep_ck   = short_op ? '0 : ck;
    sum      = hdr + op + BYTE_W'(rep_len);
    rep_zero = (rep_len == '0);

    status.marker_hit = (rx_byte == start_marker);
    status.at_close   = (byte_position == expected_bytes);
    status.oversize   = (byte_position == POS_LENGTH) && (rx_byte > MAX_LEN_BYTE);
    status.no_payload = rep_zero;
    status.run_last   = err || rep_zero || (run_idx == (rep_len - LEN_W'(1)));

    frame_header     = hdr;
    frame_opcode     = op;
    payload_valid    = !err && !rep_zero;
    payload_length   = err ? '0 : rep_len;
    payload_byte     = payload_valid ? ram_rdata : '0;
    payload_position = payload_valid ? run_idx : '0;
    checksum_ok      = !err && (rep_ck == sum);
    bulk_frame       = !err && (op == OP_BULK);
    oversize_error   = err;
    last             = status.run_last;
  end

endmodule

// ----- rtl/length_framed_packet_receiver.sv -----
// Top level of the start-marker, length-prefixed frame receiver.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   input    | in_valid / in_stall        | rx_byte
//   output   | out_valid / out_stall      | frame_header .. last (10 fields)
//   config   | APB psel/penable/pready    | start_marker at byte address 0
//
// One byte per cycle is taken while waiting for a marker or receiving a frame.
// The byte that closes a frame starts the readout: each payload result takes a
// payload RAM read (ST_FETCH), then an output (ST_OUT) that waits out any output
// stalls; a single result (no payload or oversize) goes straight to output.
// in_stall is high during readout. Synchronous reset returns to idle, marker 0x3C.
module length_framed_packet_receiver
  import lfpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] frame_header,
  output logic [BYTE_W-1:0] frame_opcode,
  output logic [LEN_W-1:0]  payload_length,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [LEN_W-1:0]  payload_position,
  output logic              payload_valid,
  output logic              checksum_ok,
  output logic              bulk_frame,
  output logic              oversize_error,
  output logic              last
);

  logic [BYTE_W-1:0] start_marker;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= MARKER_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_START_MARKER)) begin
      start_marker <= pwdata[BYTE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_START_MARKER) ? 32'(start_marker) : '0;

  lfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lfpr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .start_marker    (start_marker),
    .rx_byte         (rx_byte),
    .frame_header    (frame_header),
    .frame_opcode    (frame_opcode),
    .payload_length  (payload_length),
    .payload_byte    (payload_byte),
    .payload_position(payload_position),
    .payload_valid   (payload_valid),
    .checksum_ok     (checksum_ok),
    .bulk_frame      (bulk_frame),
    .oversize_error  (oversize_error),
    .last            (last)
  );

endmodule
